[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic concurrent assertion, clocked on the rising edge and off during reset.
`define CES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CES_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `CES_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define CES_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    `CES_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[hw/rtl/ces_pkg.sv]
package ces_pkg;

    // Sizes of the capture buffer and of the fields.
    localparam int BufferDepth = 64;
    localparam int TimeW       = 48;
    localparam int PresW       = 8;
    localparam int IndexW      = 7;
    localparam int SlotW       = 6;
    localparam int CaptW       = 16;
    localparam int BitsW       = 16;
    localparam int NsW         = 13;
    localparam int PwmNsW      = 26;
    localparam int BitCntW     = 4;

    // Divider geometry: elapsed time times four over 25 * (prescaler + 1).
    localparam int DivisorW    = 13;
    localparam int DividendW   = TimeW + 2;
    localparam int DivSteps    = DividendW / 2;
    localparam int DivCntW     = $clog2(DivSteps);

    localparam logic [DivisorW-1:0] DivScale = DivisorW'(25);
    localparam logic [9:0]          NsPerUs  = 10'd1000;

    // DShot bit periods and high times in ns.
    localparam logic [NsW-1:0] Period150 = NsW'(6667);
    localparam logic [NsW-1:0] Period300 = NsW'(3333);
    localparam logic [NsW-1:0] Period600 = NsW'(1667);

    typedef enum logic [1:0] {
        FUNC_ARM    = 2'd0,
        FUNC_TRESET = 2'd1,
        FUNC_FRAME  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        KIND_PWM      = 2'd0,
        KIND_DSHOT150 = 2'd1,
        KIND_DSHOT300 = 2'd2,
        KIND_DSHOT600 = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic arm;
        logic treset;
        logic edge_init;
        logic div_start;
        logic emit;
        logic emit_drop;
        logic edge_adv;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       armed;
        logic       store_ok;
        logic       last_edge;
        logic       div_busy;
        logic       out_free;
    } t_status;

    // Bit period of a DShot frame kind.
    function automatic logic [NsW-1:0] bit_period(input t_kind kind);
        logic [NsW-1:0] p;
        unique case (kind)
            KIND_DSHOT150: p = Period150;
            KIND_DSHOT300: p = Period300;
            KIND_DSHOT600: p = Period600;
            default:       p = '0;
        endcase
        return p;
    endfunction

    // High time of a DShot bit: floor(3T/4) for a one, floor(3T/8) for a zero.
    function automatic logic [NsW-1:0] bit_high(input t_kind kind, input logic one);
        logic [NsW-1:0] h;
        unique case (kind)
            KIND_DSHOT150: h = one ? NsW'(5000) : NsW'(2500);
            KIND_DSHOT300: h = one ? NsW'(2499) : NsW'(1249);
            KIND_DSHOT600: h = one ? NsW'(1250) : NsW'(625);
            default:       h = '0;
        endcase
        return h;
    endfunction

endpackage

[hw/rtl/ces_channels.sv]
// Request channel: one command or frame per request.
interface ces_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [ces_pkg::TimeW-1:0]     time_ns;
    logic [ces_pkg::PresW-1:0]     arm_prescaler;
    logic [ces_pkg::IndexW-1:0]    arm_edge_count;
    logic [1:0]                    frame_kind;
    logic [ces_pkg::BitsW-1:0]     frame_bits;

    modport source (
        output valid, func, time_ns, arm_prescaler, arm_edge_count, frame_kind,
               frame_bits,
        input  ready
    );
    modport sink (
        input  valid, func, time_ns, arm_prescaler, arm_edge_count, frame_kind,
               frame_bits,
        output ready
    );
endinterface

// Result channel: one captured edge per result.
interface ces_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ces_pkg::CaptW-1:0]     capture_value;
    logic                          edge_stored;
    logic [ces_pkg::SlotW-1:0]     buffer_slot;
    logic                          frame_dropped;
    logic                          transfer_done;
    logic                          last;

    modport source (
        output valid, capture_value, edge_stored, buffer_slot, frame_dropped,
               transfer_done, last,
        input  ready
    );
    modport sink (
        input  valid, capture_value, edge_stored, buffer_slot, frame_dropped,
               transfer_done, last,
        output ready
    );
endinterface

[hw/rtl/ces_div.sv]
// Restoring divider, two quotient bits per cycle; keeps the low quotient bits.
module ces_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ces_pkg::DividendW-1:0]    i_dividend,
    input  logic [ces_pkg::DivisorW-1:0]     i_divisor,
    output logic                             o_busy,
    output logic [ces_pkg::CaptW-1:0]        o_quot
);

    logic                              r_busy;
    logic [ces_pkg::DivCntW-1:0]       r_cnt;
    logic [ces_pkg::DividendW-1:0]     r_num;
    logic [ces_pkg::DivisorW-1:0]      r_rem;
    logic [ces_pkg::DivisorW-1:0]      r_den;
    logic [ces_pkg::CaptW-1:0]         r_quot;

    logic [ces_pkg::DivisorW:0]        w_t1;
    logic [ces_pkg::DivisorW:0]        w_t2;
    logic [ces_pkg::DivisorW-1:0]      w_r1;
    logic [ces_pkg::DivisorW-1:0]      w_r2;
    logic                              w_q1;
    logic                              w_q2;

    // Two dependent compare-and-subtract steps on the partial remainder.
    always_comb begin
        w_t1 = {r_rem, r_num[ces_pkg::DividendW-1]};
        w_q1 = (w_t1 >= {1'b0, r_den});
        w_r1 = w_q1 ? ces_pkg::DivisorW'(w_t1 - {1'b0, r_den})
                    : ces_pkg::DivisorW'(w_t1);
        w_t2 = {w_r1, r_num[ces_pkg::DividendW-2]};
        w_q2 = (w_t2 >= {1'b0, r_den});
        w_r2 = w_q2 ? ces_pkg::DivisorW'(w_t2 - {1'b0, r_den})
                    : ces_pkg::DivisorW'(w_t2);
    end

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == ces_pkg::DivCntW'(ces_pkg::DivSteps - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Operand and quotient registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[ces_pkg::DividendW-3:0], 2'b00};
            r_rem  <= w_r2;
            r_quot <= {r_quot[ces_pkg::CaptW-3:0], w_q1, w_q2};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

[hw/rtl/ces_dp.sv]
// Datapath: capture state, edge time generation, divider and result register.
module ces_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ces_pkg::t_cmd                    i_cmd,
    output ces_pkg::t_status                 o_status,
    input  logic [1:0]                       i_func,
    input  logic [ces_pkg::TimeW-1:0]        i_time_ns,
    input  logic [ces_pkg::PresW-1:0]        i_arm_prescaler,
    input  logic [ces_pkg::IndexW-1:0]       i_arm_edge_count,
    input  logic [1:0]                       i_frame_kind,
    input  logic [ces_pkg::BitsW-1:0]        i_frame_bits,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [ces_pkg::CaptW-1:0]        o_capture_value,
    output logic                             o_edge_stored,
    output logic [ces_pkg::SlotW-1:0]        o_buffer_slot,
    output logic                             o_frame_dropped,
    output logic                             o_transfer_done,
    output logic                             o_last
);

    // Latched request.
    logic [1:0]                      r_func;
    logic [ces_pkg::TimeW-1:0]       r_time;
    logic [ces_pkg::PresW-1:0]       r_psc_in;
    logic [ces_pkg::IndexW-1:0]      r_cnt_in;
    ces_pkg::t_kind                  r_kind;
    logic [ces_pkg::BitsW-1:0]       r_bits;
    logic [ces_pkg::PwmNsW-1:0]      r_pwm_ns;

    // Capture state.
    logic                            r_armed;
    logic [ces_pkg::DivisorW-1:0]    r_divisor;
    logic [ces_pkg::IndexW-1:0]      r_limit;
    logic [ces_pkg::IndexW-1:0]      r_index;
    logic [ces_pkg::TimeW-1:0]       r_base;

    // Edge walk.
    logic [ces_pkg::TimeW-1:0]       r_rise_el;
    logic [ces_pkg::TimeW-1:0]       r_edge_el;
    logic [ces_pkg::BitCntW-1:0]     r_bitcnt;
    logic                            r_fall;

    // Result register.
    logic                            r_out_valid;
    logic [ces_pkg::CaptW-1:0]       r_capture;
    logic                            r_stored;
    logic [ces_pkg::SlotW-1:0]       r_slot;
    logic                            r_dropped;
    logic                            r_done;
    logic                            r_last;

    logic                            w_store_ok;
    logic                            w_last_edge;
    logic [ces_pkg::IndexW-1:0]      w_idx_after;
    logic                            w_done;
    logic [ces_pkg::TimeW-1:0]       w_high;
    logic                            w_div_busy;
    logic [ces_pkg::CaptW-1:0]       w_quot;
    logic                            w_out_free;

    // Edge bookkeeping shared by the controller and the result register.
    always_comb begin
        w_store_ok  = (r_index < r_limit) && (int'(r_index) < ces_pkg::BufferDepth);
        w_last_edge = r_fall && ((r_kind == ces_pkg::KIND_PWM) || (&r_bitcnt));
        w_idx_after = w_store_ok ? r_index + 1'b1 : r_index;
        w_done      = w_last_edge && (w_idx_after >= r_limit);
        w_out_free  = !r_out_valid || i_out_ready;
        w_high      = (r_kind == ces_pkg::KIND_PWM)
                    ? ces_pkg::TimeW'(r_pwm_ns)
                    : ces_pkg::TimeW'(ces_pkg::bit_high(r_kind, r_bits[ces_pkg::BitsW-1]));
    end

    always_comb begin
        o_status.func      = r_func;
        o_status.armed     = r_armed;
        o_status.store_ok  = w_store_ok;
        o_status.last_edge = w_last_edge;
        o_status.div_busy  = w_div_busy;
        o_status.out_free  = w_out_free;
    end

    ces_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_edge_el, 2'b00}),
        .i_divisor  (r_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // Request latch; the PWM width is scaled to ns on the way in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_time   <= i_time_ns;
            r_psc_in <= i_arm_prescaler;
            r_cnt_in <= i_arm_edge_count;
            r_kind   <= ces_pkg::t_kind'(i_frame_kind);
            r_pwm_ns <= ces_pkg::PwmNsW'(i_frame_bits) * ces_pkg::PwmNsW'(ces_pkg::NsPerUs);
        end
    end

    // Frame bits shift out MSB first as the walk moves to the next bit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bits <= i_frame_bits;
        end else if (i_cmd.edge_adv && r_fall) begin
            r_bits <= {r_bits[ces_pkg::BitsW-2:0], 1'b0};
        end
    end

    // Capture state and edge walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_divisor <= ces_pkg::DivScale;
            r_limit   <= '0;
            r_index   <= '0;
            r_base    <= '0;
            r_bitcnt  <= '0;
            r_fall    <= 1'b0;
        end else begin
            if (i_cmd.arm) begin
                r_armed   <= 1'b1;
                r_divisor <= ces_pkg::DivisorW'(ces_pkg::DivScale
                             * (ces_pkg::DivisorW'(r_psc_in) + 1'b1));
                r_limit   <= r_cnt_in;
                r_index   <= '0;
                r_base    <= r_time;
            end
            if (i_cmd.treset) begin
                r_divisor <= ces_pkg::DivScale;
                r_base    <= r_time;
            end
            if (i_cmd.edge_init) begin
                r_bitcnt <= '0;
                r_fall   <= 1'b0;
            end
            if (i_cmd.edge_adv) begin
                r_fall <= !r_fall;
                if (r_fall) begin
                    r_bitcnt <= r_bitcnt + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_index <= w_idx_after;
                if (w_done) begin
                    r_armed <= 1'b0;
                end
            end
        end
    end

    // Elapsed times of the current bit start and of the current edge.
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_init) begin
            r_rise_el <= r_time - r_base;
            r_edge_el <= r_time - r_base;
        end else if (i_cmd.edge_adv) begin
            if (r_fall) begin
                r_rise_el <= r_rise_el + ces_pkg::TimeW'(ces_pkg::bit_period(r_kind));
                r_edge_el <= r_rise_el + ces_pkg::TimeW'(ces_pkg::bit_period(r_kind));
            end else begin
                r_edge_el <= r_rise_el + w_high;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_drop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_capture <= w_store_ok ? w_quot : '0;
            r_stored  <= w_store_ok;
            r_slot    <= w_store_ok ? r_index[ces_pkg::SlotW-1:0] : '0;
            r_dropped <= 1'b0;
            r_done    <= w_done;
            r_last    <= w_last_edge;
        end else if (i_cmd.emit_drop) begin
            r_capture <= '0;
            r_stored  <= 1'b0;
            r_slot    <= '0;
            r_dropped <= 1'b1;
            r_done    <= 1'b0;
            r_last    <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_capture_value = r_capture;
    assign o_edge_stored   = r_stored;
    assign o_buffer_slot   = r_slot;
    assign o_frame_dropped = r_dropped;
    assign o_transfer_done = r_done;
    assign o_last          = r_last;

endmodule

[hw/rtl/ces_ctrl.sv]
// Controller: sequences one request at a time through the datapath.
module ces_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  ces_pkg::t_status    i_status,
    output ces_pkg::t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_EDGE   = 6'b000100,
        S_DIV    = 6'b001000,
        S_EMIT   = 6'b010000,
        S_DROP   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.func)
                    ces_pkg::FUNC_ARM: begin
                        o_cmd.arm = 1'b1;
                        n_state   = S_IDLE;
                    end
                    ces_pkg::FUNC_TRESET: begin
                        o_cmd.treset = 1'b1;
                        n_state      = S_IDLE;
                    end
                    ces_pkg::FUNC_FRAME: begin
                        if (i_status.armed) begin
                            o_cmd.edge_init = 1'b1;
                            n_state         = S_EDGE;
                        end else begin
                            n_state = S_DROP;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EDGE: begin
                if (i_status.store_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_edge) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.edge_adv = 1'b1;
                        n_state        = S_EDGE;
                    end
                end
            end
            S_DROP: begin
                if (i_status.out_free) begin
                    o_cmd.emit_drop = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

[hw/rtl/capture_edge_synthesizer_top.sv]
// Input-capture timer fed by servo PWM pulses and DShot frames.
// i_req takes one request at a time: arm (prescaler, edge count, base time),
// timer reset (prescaler to zero, new base time), or a frame to expand.
// o_rsp gives one result per synthesized edge: 2 for PWM, 32 for DShot,
// and a single result flagged frame_dropped for a frame seen while disarmed.
// Arm and timer reset give no result.
// A stored edge takes one divide of the elapsed time times four by
// 25 * (prescaler + 1), run by a radix-4 divider in 25 steps, plus setup
// and output load. An edge that is not stored skips the divide.
// The request channel is ready only between requests.
// Results sit in an output register, so the last result of a frame may wait
// for the receiver while the next request is already taken.
// When the receiver stalls, the controller holds its place until the
// output register frees up; nothing is lost or repeated.
// Reset disarms the capture, clears the edge index, the limit and the base
// time, sets the prescaler to zero and empties the output register.
module capture_edge_synthesizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ces_req_if.sink     i_req,
    ces_rsp_if.source   o_rsp
);

    ces_pkg::t_cmd     w_cmd;
    ces_pkg::t_status  w_status;

    ces_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ces_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_func           (i_req.func),
        .i_time_ns        (i_req.time_ns),
        .i_arm_prescaler  (i_req.arm_prescaler),
        .i_arm_edge_count (i_req.arm_edge_count),
        .i_frame_kind     (i_req.frame_kind),
        .i_frame_bits     (i_req.frame_bits),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_capture_value  (o_rsp.capture_value),
        .o_edge_stored    (o_rsp.edge_stored),
        .o_buffer_slot    (o_rsp.buffer_slot),
        .o_frame_dropped  (o_rsp.frame_dropped),
        .o_transfer_done  (o_rsp.transfer_done),
        .o_last           (o_rsp.last)
    );

endmodule

[hw/rtl/ces_checker.sv]
`include "assert_macros.svh"

// Port-level checks on the result channel.
module ces_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [ces_pkg::CaptW-1:0]    i_capture_value,
    input logic                         i_edge_stored,
    input logic [ces_pkg::SlotW-1:0]    i_buffer_slot,
    input logic                         i_frame_dropped,
    input logic                         i_transfer_done,
    input logic                         i_last
);

    // A stalled result stays and keeps its capture value, slot and last flag.
    `CES_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_capture_value) && $stable(i_buffer_slot) && $stable(i_last), "result changed while stalled")

    // A dropped frame is a single, empty, closing result.
    `CES_ASSERT_IMP(a_drop, i_clk, i_rst_n, i_out_valid && i_frame_dropped, i_last && !i_edge_stored && !i_transfer_done && (i_capture_value == '0), "malformed dropped-frame result")

    // An edge that was not stored carries neither a count nor a slot.
    `CES_ASSERT_IMP(a_unstored, i_clk, i_rst_n, i_out_valid && !i_edge_stored, (i_capture_value == '0) && (i_buffer_slot == '0), "unstored edge carries data")

    // Completion is flagged only on the closing result of a frame.
    `CES_ASSERT_IMP(a_done_last, i_clk, i_rst_n, i_out_valid && i_transfer_done, i_last && !i_frame_dropped, "transfer done off the last result")

endmodule

bind capture_edge_synthesizer_top ces_checker u_ces_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_capture_value (o_rsp.capture_value),
    .i_edge_stored   (o_rsp.edge_stored),
    .i_buffer_slot   (o_rsp.buffer_slot),
    .i_frame_dropped (o_rsp.frame_dropped),
    .i_transfer_done (o_rsp.transfer_done),
    .i_last          (o_rsp.last)
);

[verif/tb_capture_edge_synthesizer_top.sv]
`timescale 1ns / 1ps

module tb_capture_edge_synthesizer_top;

    // Function code that the block ignores.
    localparam logic [1:0] FuncUnused  = 2'd3;
    localparam int         RandomItems = 180;
    localparam int         StallLimit  = 2000;
    localparam int         DrainCycles = 100;

    typedef struct packed {
        logic [1:0]                  func;
        logic [ces_pkg::TimeW-1:0]   time_ns;
        logic [ces_pkg::PresW-1:0]   prescaler;
        logic [ces_pkg::IndexW-1:0]  edge_count;
        ces_pkg::t_kind              kind;
        logic [ces_pkg::BitsW-1:0]   frame_bits;
    } t_capture_req;

    typedef struct packed {
        logic [ces_pkg::CaptW-1:0] capture_value;
        logic                      edge_stored;
        logic [ces_pkg::SlotW-1:0] buffer_slot;
        logic                      frame_dropped;
        logic                      transfer_done;
        logic                      last;
    } t_edge_result;

    typedef struct packed {
        t_capture_req req;
        logic         dropped_expected;
    } t_stim_row;

    // A frame seen while the capture is disarmed gives exactly this result.
    localparam t_edge_result DroppedFrame = {16'd0, 1'b0, 6'd0, 1'b1, 1'b0, 1'b1};

    logic i_clk = 1'b0;
    logic i_rst_n;

    ces_req_if req_ch ();
    ces_rsp_if rsp_ch ();

    capture_edge_synthesizer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the capture timer state.
    logic                        shadow_armed;
    logic [ces_pkg::PresW-1:0]   cap_psc;
    logic [ces_pkg::IndexW-1:0]  cap_limit;
    logic [ces_pkg::IndexW-1:0]  shadow_index;
    logic [ces_pkg::TimeW-1:0]   cap_base;

    t_edge_result fresh_edges[$];
    t_edge_result expected_edges[$];
    int           mismatches = 0;
    bit           src_idle   = 1'b1;
    bit           snk_idle   = 1'b1;

    // Timer count at time t: elapsed time times four over 25 * (prescaler + 1).
    function automatic logic [ces_pkg::CaptW-1:0] timer_count(
        input logic [ces_pkg::TimeW-1:0] t);
        logic [ces_pkg::TimeW-1:0] elapsed;
        logic [63:0]               scaled;
        logic [63:0]               divisor;
        logic [63:0]               quotient;
        elapsed  = t - cap_base;
        scaled   = {14'd0, elapsed, 2'b00};
        divisor  = 64'd25 * (64'(cap_psc) + 64'd1);
        quotient = scaled / divisor;
        return quotient[ces_pkg::CaptW-1:0];
    endfunction

    // One synthesized edge; it is written to the buffer only below both limits.
    function automatic t_edge_result capture_edge(input logic [ces_pkg::TimeW-1:0] t);
        t_edge_result res;
        res = '0;
        if (shadow_index < cap_limit && shadow_index < ces_pkg::BufferDepth) begin
            res.capture_value = timer_count(t);
            res.edge_stored   = 1'b1;
            res.buffer_slot   = shadow_index[ces_pkg::SlotW-1:0];
            shadow_index      = shadow_index + 7'd1;
        end
        return res;
    endfunction

    // Update the shadow state for one request and collect the edges it causes.
    task automatic expand_request(input t_capture_req r);
        logic [ces_pkg::TimeW-1:0] period;
        logic [ces_pkg::TimeW-1:0] high_ns;
        logic [ces_pkg::TimeW-1:0] start;
        t_edge_result              tail;
        fresh_edges.delete();
        case (r.func)
            ces_pkg::FUNC_ARM: begin
                cap_psc      = r.prescaler;
                cap_limit    = r.edge_count;
                shadow_index = '0;
                cap_base     = r.time_ns;
                shadow_armed = 1'b1;
            end
            ces_pkg::FUNC_TRESET: begin
                cap_psc  = '0;
                cap_base = r.time_ns;
            end
            ces_pkg::FUNC_FRAME: begin
                if (!shadow_armed) begin
                    fresh_edges.push_back(DroppedFrame);
                end else begin
                    if (r.kind == ces_pkg::KIND_PWM) begin
                        fresh_edges.push_back(capture_edge(r.time_ns));
                        fresh_edges.push_back(
                            capture_edge(r.time_ns + 48'(r.frame_bits) * 48'd1000));
                    end else begin
                        case (r.kind)
                            ces_pkg::KIND_DSHOT150: period = 48'(ces_pkg::Period150);
                            ces_pkg::KIND_DSHOT300: period = 48'(ces_pkg::Period300);
                            default:                period = 48'(ces_pkg::Period600);
                        endcase
                        // Sixteen bits, most significant first: rise, then fall.
                        for (int i = 0; i < 16; i++) begin
                            start   = r.time_ns + 48'(i) * period;
                            high_ns = r.frame_bits[15-i] ? (period * 48'd3) / 48'd4
                                                         : (period * 48'd3) / 48'd8;
                            fresh_edges.push_back(capture_edge(start));
                            fresh_edges.push_back(capture_edge(start + high_ns));
                        end
                    end
                    tail = fresh_edges.pop_back();
                    if (shadow_index >= cap_limit) begin
                        shadow_armed       = 1'b0;
                        tail.transfer_done = 1'b1;
                    end
                    tail.last = 1'b1;
                    fresh_edges.push_back(tail);
                end
            end
            default: ;
        endcase
    endtask

    // Present one request, wait for it to be taken, then record what it should cause.
    task automatic issue_request(input t_capture_req r, input logic dropped_expected);
        int gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.func           <= r.func;
        req_ch.time_ns        <= r.time_ns;
        req_ch.arm_prescaler  <= r.prescaler;
        req_ch.arm_edge_count <= r.edge_count;
        req_ch.frame_kind     <= r.kind;
        req_ch.frame_bits     <= r.frame_bits;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expand_request(r);
        if (dropped_expected) begin
            expected_edges.push_back(DroppedFrame);
        end else begin
            foreach (fresh_edges[i]) expected_edges.push_back(fresh_edges[i]);
        end
    endtask

    function automatic t_stim_row stim(input logic [1:0] f,
                                       input logic [ces_pkg::TimeW-1:0] t,
                                       input logic [ces_pkg::PresW-1:0] p,
                                       input logic [ces_pkg::IndexW-1:0] c,
                                       input ces_pkg::t_kind k,
                                       input logic [ces_pkg::BitsW-1:0] b,
                                       input logic dropped);
        t_stim_row row;
        row.req              = {f, t, p, c, k, b};
        row.dropped_expected = dropped;
        return row;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare one taken result with the oldest expected edge.
    task automatic check_edge(input t_edge_result got);
        t_edge_result want;
        if (expected_edges.size() == 0) begin
            $error("result with nothing expected: capture_value %0d, last %0d",
                   got.capture_value, got.last);
            mismatches++;
        end else begin
            want = expected_edges.pop_front();
            compare_field("capture_value", want.capture_value, got.capture_value);
            compare_field("edge_stored", 16'(want.edge_stored), 16'(got.edge_stored));
            compare_field("buffer_slot", 16'(want.buffer_slot), 16'(got.buffer_slot));
            compare_field("frame_dropped", 16'(want.frame_dropped), 16'(got.frame_dropped));
            compare_field("transfer_done", 16'(want.transfer_done), 16'(got.transfer_done));
            compare_field("last", 16'(want.last), 16'(got.last));
        end
    endtask

    // Result side: random ready gaps, every taken result is checked.
    initial begin : result_sink
        int           gap;
        int           taken;
        t_edge_result got;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = snk_idle ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            got = {rsp_ch.capture_value, rsp_ch.edge_stored, rsp_ch.buffer_slot,
                   rsp_ch.frame_dropped, rsp_ch.transfer_done, rsp_ch.last};
            check_edge(got);
            taken++;
            if (taken % 30 == 0) snk_idle = ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog: too many cycles in which neither channel moves a request or a result.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < StallLimit) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_capture_edge_synthesizer_top failed");
        $finish;
    end

    initial begin : stimulus
        t_stim_row                 directed_rows[$];
        t_capture_req              r;
        logic [ces_pkg::TimeW-1:0] stim_now;
        int                        sent;
        int                        loops;
        int                        pick;
        int                        sel;

        // Known values on every input from the start.
        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.func           <= ces_pkg::FUNC_ARM;
        req_ch.time_ns        <= '0;
        req_ch.arm_prescaler  <= '0;
        req_ch.arm_edge_count <= '0;
        req_ch.frame_kind     <= ces_pkg::KIND_PWM;
        req_ch.frame_bits     <= '0;
        shadow_armed = 1'b0;
        cap_psc      = '0;
        cap_limit    = '0;
        shadow_index = '0;
        cap_base     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; the last column marks rows whose only result is a drop.
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd0, 8'd0, 7'd0,
                                     ces_pkg::KIND_PWM, 16'd1500, 1'b1));
        directed_rows.push_back(stim(FuncUnused, 48'h8000_0000_0001, 8'hFF, 7'd64,
                                     ces_pkg::KIND_DSHOT600, 16'hFFFF, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_TRESET, 48'd0, 8'h5A, 7'd10,
                                     ces_pkg::KIND_PWM, 16'd0, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_ARM, 48'd0, 8'd0, 7'd64,
                                     ces_pkg::KIND_PWM, 16'd0, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd0, 8'd0, 7'd0,
                                     ces_pkg::KIND_PWM, 16'd0, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd1000, 8'd0, 7'd0,
                                     ces_pkg::KIND_PWM, 16'hFFFF, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd70_000_000, 8'd0, 7'd0,
                                     ces_pkg::KIND_DSHOT150, 16'hFFFF, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd70_200_000, 8'd0, 7'd0,
                                     ces_pkg::KIND_DSHOT300, 16'h0000, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd70_300_000, 8'd0, 7'd0,
                                     ces_pkg::KIND_DSHOT600, 16'hA5C3, 1'b1));
        // Zero edge count, armed at the very top of the time range.
        directed_rows.push_back(stim(ces_pkg::FUNC_ARM, 48'hFFFF_FFFF_FFFF, 8'hFF, 7'd0,
                                     ces_pkg::KIND_PWM, 16'd0, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'hFFFF_FFFF_FF9C, 8'd0, 7'd0,
                                     ces_pkg::KIND_DSHOT600, 16'h8001, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd5000, 8'd0, 7'd0,
                                     ces_pkg::KIND_PWM, 16'd1000, 1'b1));
        // Base time just below the wrap, frames just past it.
        directed_rows.push_back(stim(ces_pkg::FUNC_ARM, 48'hFFFF_FFFF_EC78, 8'd7, 7'd3,
                                     ces_pkg::KIND_PWM, 16'd0, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_TRESET, 48'hFFFF_FFFF_F830, 8'hFF,
                                     7'd127, ces_pkg::KIND_DSHOT150, 16'hFFFF, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd10, 8'd0, 7'd0,
                                     ces_pkg::KIND_PWM, 16'd1234, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd500_000, 8'd0, 7'd0,
                                     ces_pkg::KIND_DSHOT150, 16'h1234, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_ARM, 48'h5555_5555_5555, 8'd128, 7'd1,
                                     ces_pkg::KIND_PWM, 16'd0, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'hAAAA_AAAA_AAAA, 8'd0, 7'd0,
                                     ces_pkg::KIND_PWM, 16'h8000, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_ARM, 48'd0, 8'd3, 7'd33,
                                     ces_pkg::KIND_PWM, 16'd0, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd123_456_789, 8'd0, 7'd0,
                                     ces_pkg::KIND_DSHOT300, 16'h7FFE, 1'b0));
        directed_rows.push_back(stim(ces_pkg::FUNC_FRAME, 48'd123_600_000, 8'd0, 7'd0,
                                     ces_pkg::KIND_PWM, 16'd1, 1'b0));

        foreach (directed_rows[i])
            issue_request(directed_rows[i].req, directed_rows[i].dropped_expected);

        // Random part: mostly arm-then-frames sequences, with resets and noise mixed in.
        stim_now = 48'd200_000_000;
        sent     = 0;
        loops    = 0;
        while (sent < RandomItems) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                stim_now = ces_pkg::TimeW'({$urandom, $urandom});
            else if (sel == 1)
                stim_now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 400_000));
            else
                stim_now = stim_now + 48'($urandom_range(500, 150_000));

            r.time_ns   = stim_now;
            r.prescaler = 8'($urandom_range(0, 255));
            sel = $urandom_range(0, 9);
            if (sel == 0)
                r.edge_count = 7'd0;
            else if (sel == 1)
                r.edge_count = 7'd64;
            else
                r.edge_count = 7'($urandom_range(1, 64));
            r.kind = ces_pkg::t_kind'($urandom_range(0, 3));
            if (r.kind == ces_pkg::KIND_PWM && $urandom_range(0, 9) < 7)
                r.frame_bits = 16'($urandom_range(900, 2100));
            else
                r.frame_bits = 16'($urandom_range(0, 65535));

            pick = $urandom_range(0, 99);
            if (!shadow_armed)
                r.func = (pick < 80) ? ces_pkg::FUNC_ARM : ces_pkg::FUNC_FRAME;
            else if (pick < 5)
                r.func = ces_pkg::FUNC_ARM;
            else if (pick < 13)
                r.func = ces_pkg::FUNC_TRESET;
            else if (pick < 15)
                r.func = FuncUnused;
            else
                r.func = ces_pkg::FUNC_FRAME;

            issue_request(r, 1'b0);
            if (r.func != FuncUnused) sent++;
            loops++;
            if (loops % 25 == 0) src_idle = ($urandom_range(0, 3) != 0);
        end
        req_ch.valid <= 1'b0;

        // Drain every expected edge, then give the block time to show anything extra.
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_capture_edge_synthesizer_top passed");
        else
            $display("tb_capture_edge_synthesizer_top failed");
        $finish;
    end

endmodule
